// ----- hw/rtl/breakpoint_comparator_table_assert.svh -----
// Assertion macros for the breakpoint comparator table RTL.
// Included by bct_ctrl, which carries the concurrent assertions; no other dependencies.
`ifndef BREAKPOINT_COMPARATOR_TABLE_ASSERT_SVH
`define BREAKPOINT_COMPARATOR_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bct_pkg.sv -----
// Package for the breakpoint comparator table: beat types, control and status types,
// operation codes, comparator word constants and the word builder. No dependencies.
`timescale 1ns / 1ps

package bct_pkg;

    typedef enum logic [1:0] {
        OP_SET       = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_DISABLE   = 2'd2,
        OP_CLEAR_ALL = 2'd3
    } bct_op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
        logic [2:0]  size;
    } bct_cmd_t;

    typedef struct packed {
        logic        success;
        logic [2:0]  slot_index;
        logic [31:0] comparator_word;
    } bct_rsp_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic capture;
        logic commit;
    } bct_ctl_t;

    typedef struct packed {
        logic cmp_pend;
        logic hit;
        logic cmp_last;
        logic clear_all;
    } bct_sts_t;

    localparam logic [31:0] ADDR_MASK    = 32'h0fff_fffc;
    localparam logic [31:0] HALF_SEL     = 32'h0000_0002;
    localparam logic [2:0]  SIZE_DEFAULT = 3'd2;
    localparam logic [2:0]  SIZE_HALF    = 3'd2;
    localparam logic [31:0] REPL_LOW     = 32'h4000_0000;
    localparam logic [31:0] REPL_HIGH    = 32'h8000_0000;
    localparam logic [31:0] REPL_WORD    = 32'hc000_0000;
    localparam logic [31:0] ENABLE_BIT   = 32'h0000_0001;

    function automatic logic [31:0] bct_build_word(input logic [31:0] addr,
                                                   input logic [2:0]  sz);
        logic [2:0]  eff_sz;
        logic [31:0] repl;
        eff_sz = (sz == 3'd0) ? SIZE_DEFAULT : sz;
        if (eff_sz == SIZE_HALF)
        begin
            repl = ((addr & HALF_SEL) != 32'd0) ? REPL_HIGH : REPL_LOW;
        end
        else
        begin
            repl = REPL_WORD;
        end
        return repl | (addr & ADDR_MASK) | ENABLE_BIT;
    endfunction

endpackage

// ----- hw/rtl/breakpoint_comparator_table.sv -----
// Top level of the breakpoint comparator table.
// Depends on bct_pkg, bct_ctrl and bct_datapath.
//
//   Channel | Direction | Handshake           | Beat
//   cmd     | in        | cmd_valid/cmd_ready | bct_cmd_t (operation, address, size)
//   rsp     | out       | rsp_valid/rsp_ready | bct_rsp_t (success, slot_index, word)
//
// A set, clear or disable scans the code slots one per cycle through the single
// memory read port until a slot matches or the last code slot has been compared.
// Clear all empties the table through its valid bits.
// After reset the table reads as all zero; no clearing pass is needed.
// A result held in the output register does not block the next accept; a new
// result waits in its commit state until the previous beat has been taken.
`timescale 1ns / 1ps

module breakpoint_comparator_table
    import bct_pkg::*;
#(
    parameter int CODE_SLOTS    = 6,
    parameter int LITERAL_SLOTS = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  bct_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bct_rsp_t rsp
);

    localparam int TOTAL_SLOTS = CODE_SLOTS + LITERAL_SLOTS;
    localparam int IDX_W       = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

    bct_ctl_t         ctl;
    bct_sts_t         sts;
    logic [IDX_W-1:0] rd_addr;

    bct_ctrl #(
        .CODE_SLOTS    (CODE_SLOTS),
        .LITERAL_SLOTS (LITERAL_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .ctl       (ctl),
        .rd_addr   (rd_addr)
    );

    bct_datapath #(
        .CODE_SLOTS    (CODE_SLOTS),
        .LITERAL_SLOTS (LITERAL_SLOTS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .sts     (sts),
        .rsp     (rsp)
    );

endmodule

// ----- hw/rtl/bct_datapath.sv -----
// Datapath of the breakpoint comparator table: comparator memory, valid bits,
// slot matching and the result register. Depends on bct_pkg.
`timescale 1ns / 1ps

module bct_datapath
    import bct_pkg::*;
#(
    parameter int CODE_SLOTS    = 6,
    parameter int LITERAL_SLOTS = 2,
    localparam int TOTAL_SLOTS  = CODE_SLOTS + LITERAL_SLOTS,
    localparam int IDX_W        = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  bct_cmd_t         cmd,
    input  bct_ctl_t         ctl,
    input  logic [IDX_W-1:0] rd_addr,
    output bct_sts_t         sts,
    output bct_rsp_t         rsp
);

    logic [31:0]            comparator_mem [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] valid_reg;

    logic [1:0]       op_reg;
    logic [31:0]      addr_reg;
    logic [31:0]      word_reg;
    logic [31:0]      mem_q_reg;
    logic             vld_q_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             hold_hit_reg;
    logic [IDX_W-1:0] hold_idx_reg;
    logic [31:0]      hold_word_reg;
    bct_rsp_t         rsp_reg;

    logic [31:0]      rd_word;
    logic             hit;
    logic [31:0]      new_word;
    logic [IDX_W+2:0] idx_ext;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            mem_q_reg <= comparator_mem[rd_addr];
        end
        if (ctl.commit && (op_reg != OP_CLEAR_ALL) && hold_hit_reg)
        begin
            comparator_mem[hold_idx_reg] <= hold_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.rd_en;
            if (ctl.rd_en)
            begin
                vld_q_reg <= valid_reg[rd_addr];
            end
            if (ctl.commit)
            begin
                if (op_reg == OP_CLEAR_ALL)
                begin
                    valid_reg <= '0;
                end
                else if (hold_hit_reg)
                begin
                    valid_reg[hold_idx_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= cmd.operation;
            addr_reg <= cmd.address;
            word_reg <= bct_build_word(cmd.address, cmd.size);
        end
        if (ctl.rd_en)
        begin
            cmp_idx_reg <= rd_addr;
        end
        if (ctl.capture)
        begin
            hold_hit_reg  <= hit;
            hold_idx_reg  <= cmp_idx_reg;
            hold_word_reg <= new_word;
        end
        if (ctl.commit)
        begin
            if (op_reg == OP_CLEAR_ALL)
            begin
                rsp_reg <= '{success: 1'b1, slot_index: 3'd0, comparator_word: 32'd0};
            end
            else if (hold_hit_reg)
            begin
                rsp_reg <= '{success: 1'b1, slot_index: idx_ext[2:0],
                             comparator_word: hold_word_reg};
            end
            else
            begin
                rsp_reg <= '{success: 1'b0, slot_index: 3'd0, comparator_word: 32'd0};
            end
        end
    end

    // A slot that was never written since reset or the last clear all reads as zero.
    assign rd_word = vld_q_reg ? mem_q_reg : 32'd0;
    assign idx_ext = {3'b000, hold_idx_reg};

    always_comb
    begin
        unique case (bct_op_t'(op_reg))
            OP_SET:
            begin
                hit      = ((rd_word & ENABLE_BIT) == 32'd0);
                new_word = word_reg;
            end
            OP_CLEAR:
            begin
                hit      = ((rd_word | ENABLE_BIT) == word_reg);
                new_word = 32'd0;
            end
            OP_DISABLE:
            begin
                hit      = ((rd_word & ADDR_MASK) == (addr_reg & ADDR_MASK));
                new_word = rd_word & ~ENABLE_BIT;
            end
            default:
            begin
                hit      = 1'b0;
                new_word = 32'd0;
            end
        endcase
    end

    assign sts.cmp_pend  = pend_reg;
    assign sts.hit       = hit;
    assign sts.cmp_last  = (cmp_idx_reg == IDX_W'(CODE_SLOTS - 1));
    assign sts.clear_all = (op_reg == OP_CLEAR_ALL);
    assign rsp           = rsp_reg;

endmodule

// ----- hw/rtl/bct_ctrl.sv -----
// Controller of the breakpoint comparator table: command handshake, slot scan
// sequencing and result valid. Depends on bct_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "breakpoint_comparator_table_assert.svh"

module bct_ctrl
    import bct_pkg::*;
#(
    parameter int CODE_SLOTS    = 6,
    parameter int LITERAL_SLOTS = 2,
    localparam int TOTAL_SLOTS  = CODE_SLOTS + LITERAL_SLOTS,
    localparam int IDX_W        = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1,
    localparam int CNT_W        = $clog2(TOTAL_SLOTS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  bct_sts_t         sts,
    output bct_ctl_t         ctl,
    output logic [IDX_W-1:0] rd_addr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign out_free    = !out_valid_reg || rsp_ready;
    assign cmd_ready   = (state_reg == ST_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign rd_addr     = cnt_reg[IDX_W-1:0];

    assign ctl.load    = cmd_valid && (state_reg == ST_IDLE);
    assign ctl.rd_en   = (state_reg == ST_SCAN) && !sts.clear_all
                         && (cnt_reg < CNT_W'(CODE_SLOTS));
    assign ctl.capture = (state_reg == ST_SCAN) && !sts.clear_all && sts.cmp_pend
                         && (sts.hit || sts.cmp_last);
    assign ctl.commit  = (state_reg == ST_COMMIT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (ctl.rd_en)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (sts.clear_all || ctl.capture)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `BCT_ASSERT_SAME(a_commit_needs_room, clk, rst_n, ctl.commit, !out_valid_reg || rsp_ready, "Result overwritten before it was taken.")
    `BCT_ASSERT_NEXT(a_commit_gives_beat, clk, rst_n, ctl.commit, rsp_valid, "Committed result not presented.")
    `BCT_ASSERT_NEXT(a_accept_busy, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "Command accepted while one is in progress.")
    `BCT_ASSERT_SAME(a_read_in_range, clk, rst_n, ctl.rd_en, cnt_reg < CNT_W'(CODE_SLOTS), "Scan read beyond the code slots.")

endmodule
